/* design/svpwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package svpwm_pkg;

  // angle and sine table resolution
  localparam int ANGLE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;
  localparam int ROM_AW          = SINE_TABLE_BITS + 1;

  // fixed field widths
  localparam int UQ_W    = 16;
  localparam int EANG_W  = 16;
  localparam int CMP_W   = 16;
  localparam int SEC_W   = 3;
  localparam int INV_W   = 23;
  localparam int HALF_W  = 16;
  localparam int CFG_W   = 23;
  localparam int CFG_AW  = 1;

  // datapath widths
  localparam int P_W     = ANGLE_BITS + 3;
  localparam int SINE_W  = 15;
  localparam int MAG_W   = 17;
  localparam int PROD_W  = 30;
  localparam int SQ3_W   = 16;
  localparam int V_W     = 31;
  localparam int T_W     = 23;
  localparam int X_W     = T_W + 1;
  localparam int D2_W    = T_W + 4;
  localparam int DUTY_W  = 17;

  localparam int PIPE_DEPTH = 7;

  localparam logic [63:0]      PI3_Q30   = 64'd1124419809;
  localparam logic [SQ3_W-1:0] SQRT3_Q15 = 16'd56756;
  localparam int               ONE_Q16   = 65536;

  localparam logic [INV_W-1:0]  INV_SUPPLY_RST  = 23'd523778;
  localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd3200;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_INV_SUPPLY  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_HALF_PERIOD = 1'b1;

  // sector codes, zero based
  localparam logic [SEC_W-1:0] SEC0 = 3'd0;
  localparam logic [SEC_W-1:0] SEC1 = 3'd1;
  localparam logic [SEC_W-1:0] SEC2 = 3'd2;
  localparam logic [SEC_W-1:0] SEC3 = 3'd3;
  localparam logic [SEC_W-1:0] SEC4 = 3'd4;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_N];

  // sin(k/N * pi/3) in Q15, Q30 taylor series to x^9, elaboration only
  function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (k * PI3_Q30) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - t;
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + t;
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - t;
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + t;
    return SINE_W'((s + 64'd16384) >> 15);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= SINE_N; k++) begin
      rom[k] = sine_entry(64'(k));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // twice the duty is 2x + 1 - t1 - t2, clamped to 0..2, then halved
  function automatic logic [DUTY_W-1:0] duty_q16(input logic [X_W-1:0] x,
                                                 input logic [T_W-1:0] t1,
                                                 input logic [T_W-1:0] t2);
    logic [D2_W-1:0] d2;
    logic [DUTY_W-1:0] duty;
    d2 = (D2_W'(x) << 1) + D2_W'(ONE_Q16) - D2_W'(t1) - D2_W'(t2);
    if (d2[D2_W-1]) begin
      duty = '0;
    end else if (d2 > D2_W'(2 * ONE_Q16)) begin
      duty = DUTY_W'(ONE_Q16);
    end else begin
      duty = d2[DUTY_W:1];
    end
    return duty;
  endfunction

endpackage

`default_nettype wire

/* design/space_vector_pwm_modulator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Three phase space vector modulator.
// Input beat: in_uq_mv (signed mV command) and in_elec_angle (turn fraction,
// 65536 = one turn). A negative command turns the vector by half a turn.
// Output beat: the three comparator values (duty times half period) and the
// sector number 1..6. One result per input beat, in order.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 = inverse supply, 1 = half period); write only while the block is idle,
// which the block itself does not enforce. Pipeline: seven register stages
// (angle/sector, sine rom, three multiplier stages, duty clamp, period
// scaling) feeding out_*. Throughput: one beat per cycle while out_stall is low.
// Each stage holds only while its successor is full and stalled, so bubbles
// close up under out_stall and in_stall rises only when all seven stages are
// full. Reset (synchronous, rst_n low) empties the pipeline and loads the
// register reset values (inverse supply 523778, half period 3200).
module space_vector_pwm_modulator
  import svpwm_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  signed [UQ_W-1:0]   in_uq_mv,
  input  wire         [EANG_W-1:0] in_elec_angle,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic        [CMP_W-1:0]  out_compare_a,
  output logic        [CMP_W-1:0]  out_compare_b,
  output logic        [CMP_W-1:0]  out_compare_c,
  output logic        [SEC_W-1:0]  out_sector,
  input  wire                      cfg_wr_en,
  input  wire         [CFG_AW-1:0] cfg_index,
  input  wire         [CFG_W-1:0]  cfg_data
);

  logic [INV_W-1:0]      inv_supply_r;
  logic [HALF_W-1:0]     half_period_r;
  logic [PIPE_DEPTH:1]   vld_r;
  logic [PIPE_DEPTH:1]   en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_supply_r  <= INV_SUPPLY_RST;
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_INV_SUPPLY:  inv_supply_r  <= cfg_data[INV_W-1:0];
        REG_HALF_PERIOD: half_period_r <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[PIPE_DEPTH] = !vld_r[PIPE_DEPTH] || !out_stall;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld_r[PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: magnitude, half turn for negative command, sector and offset
  logic [UQ_W-1:0]            uq_bits;
  logic                       uq_neg;
  logic [MAG_W-1:0]           mag;
  logic [ANGLE_BITS-1:0]      ang;
  logic [ANGLE_BITS-1:0]      ang_adj;
  logic [P_W-1:0]             p6;
  logic [SEC_W-1:0]           s1_sec_r;
  logic [SINE_TABLE_BITS-1:0] s1_idx_r;
  logic [MAG_W-1:0]           s1_mag_r;

  assign uq_bits = in_uq_mv;
  assign uq_neg  = uq_bits[UQ_W-1];
  assign mag     = uq_neg ? (MAG_W'(ONE_Q16) - MAG_W'(uq_bits)) : MAG_W'(uq_bits);
  assign ang     = ANGLE_BITS'(in_elec_angle);
  assign ang_adj = {ang[ANGLE_BITS-1] ^ uq_neg, ang[ANGLE_BITS-2:0]};
  assign p6      = (P_W'(ang_adj) << 2) + (P_W'(ang_adj) << 1);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sec_r <= p6[P_W-1:ANGLE_BITS];
      s1_idx_r <= p6[ANGLE_BITS-1:ANGLE_BITS-SINE_TABLE_BITS];
      s1_mag_r <= mag;
    end
  end

  // stage 2: sine rom, mirrored entry for t1 and direct entry for t2
  logic [ROM_AW-1:0] addr_t1;
  logic [ROM_AW-1:0] addr_t2;
  logic [SINE_W-1:0] s2_sin1_r;
  logic [SINE_W-1:0] s2_sin2_r;
  logic [MAG_W-1:0]  s2_mag_r;
  logic [SEC_W-1:0]  s2_sec_r;

  assign addr_t2 = ROM_AW'(s1_idx_r);
  assign addr_t1 = ROM_AW'(SINE_N) - addr_t2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_sin1_r <= SINE_ROM[addr_t1];
      s2_sin2_r <= SINE_ROM[addr_t2];
      s2_mag_r  <= s1_mag_r;
      s2_sec_r  <= s1_sec_r;
    end
  end

  // stage 3: sine times magnitude, below 2^30 as both are at most 2^15
  logic [SINE_W+MAG_W-1:0] prod1;
  logic [SINE_W+MAG_W-1:0] prod2;
  logic [PROD_W-1:0]       s3_p1_r;
  logic [PROD_W-1:0]       s3_p2_r;
  logic [SEC_W-1:0]        s3_sec_r;

  assign prod1 = (SINE_W+MAG_W)'(s2_sin1_r) * (SINE_W+MAG_W)'(s2_mag_r);
  assign prod2 = (SINE_W+MAG_W)'(s2_sin2_r) * (SINE_W+MAG_W)'(s2_mag_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_p1_r  <= prod1[PROD_W-1:0];
      s3_p2_r  <= prod2[PROD_W-1:0];
      s3_sec_r <= s2_sec_r;
    end
  end

  // stage 4: times sqrt3 in Q15
  logic [PROD_W+SQ3_W-1:0] vq1;
  logic [PROD_W+SQ3_W-1:0] vq2;
  logic [V_W-1:0]          s4_v1_r;
  logic [V_W-1:0]          s4_v2_r;
  logic [SEC_W-1:0]        s4_sec_r;

  assign vq1 = (PROD_W+SQ3_W)'(s3_p1_r) * (PROD_W+SQ3_W)'(SQRT3_Q15);
  assign vq2 = (PROD_W+SQ3_W)'(s3_p2_r) * (PROD_W+SQ3_W)'(SQRT3_Q15);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_v1_r  <= vq1[PROD_W+SQ3_W-1:15];
      s4_v2_r  <= vq2[PROD_W+SQ3_W-1:15];
      s4_sec_r <= s3_sec_r;
    end
  end

  // stage 5: divide by supply as multiply by its Q32 inverse
  logic [V_W+INV_W-1:0] tq1;
  logic [V_W+INV_W-1:0] tq2;
  logic [T_W-1:0]       s5_t1_r;
  logic [T_W-1:0]       s5_t2_r;
  logic [SEC_W-1:0]     s5_sec_r;

  assign tq1 = (V_W+INV_W)'(s4_v1_r) * (V_W+INV_W)'(inv_supply_r);
  assign tq2 = (V_W+INV_W)'(s4_v2_r) * (V_W+INV_W)'(inv_supply_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_t1_r  <= tq1[V_W+INV_W-1:31];
      s5_t2_r  <= tq2[V_W+INV_W-1:31];
      s5_sec_r <= s4_sec_r;
    end
  end

  // stage 6: per-sector active parts, clamped duties
  logic [X_W-1:0]    x_sum;
  logic [X_W-1:0]    x_a;
  logic [X_W-1:0]    x_b;
  logic [X_W-1:0]    x_c;
  logic [DUTY_W-1:0] s6_duty_a_r;
  logic [DUTY_W-1:0] s6_duty_b_r;
  logic [DUTY_W-1:0] s6_duty_c_r;
  logic [SEC_W-1:0]  s6_sec_r;

  assign x_sum = X_W'(s5_t1_r) + X_W'(s5_t2_r);

  always_comb begin
    case (s5_sec_r)
      SEC0: begin
        x_a = x_sum;           x_b = X_W'(s5_t2_r); x_c = '0;
      end
      SEC1: begin
        x_a = X_W'(s5_t1_r);   x_b = x_sum;         x_c = '0;
      end
      SEC2: begin
        x_a = '0;              x_b = x_sum;         x_c = X_W'(s5_t2_r);
      end
      SEC3: begin
        x_a = '0;              x_b = X_W'(s5_t1_r); x_c = x_sum;
      end
      SEC4: begin
        x_a = X_W'(s5_t2_r);   x_b = '0;            x_c = x_sum;
      end
      default: begin
        x_a = x_sum;           x_b = '0;            x_c = X_W'(s5_t1_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_duty_a_r <= duty_q16(x_a, s5_t1_r, s5_t2_r);
      s6_duty_b_r <= duty_q16(x_b, s5_t1_r, s5_t2_r);
      s6_duty_c_r <= duty_q16(x_c, s5_t1_r, s5_t2_r);
      s6_sec_r    <= s5_sec_r;
    end
  end

  // stage 7: duty times half period, output register
  logic [DUTY_W+HALF_W-1:0] cq_a;
  logic [DUTY_W+HALF_W-1:0] cq_b;
  logic [DUTY_W+HALF_W-1:0] cq_c;

  assign cq_a = (DUTY_W+HALF_W)'(s6_duty_a_r) * (DUTY_W+HALF_W)'(half_period_r);
  assign cq_b = (DUTY_W+HALF_W)'(s6_duty_b_r) * (DUTY_W+HALF_W)'(half_period_r);
  assign cq_c = (DUTY_W+HALF_W)'(s6_duty_c_r) * (DUTY_W+HALF_W)'(half_period_r);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_compare_a <= cq_a[CMP_W+15:16];
      out_compare_b <= cq_b[CMP_W+15:16];
      out_compare_c <= cq_c[CMP_W+15:16];
      out_sector    <= s6_sec_r + SEC_W'(1);
    end
  end

endmodule

`default_nettype wire

/* design/svpwm_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module svpwm_chk
  import svpwm_pkg::*;
(
  input wire               clk,
  input wire               rst_n,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire [CMP_W-1:0]   out_compare_a,
  input wire [CMP_W-1:0]   out_compare_b,
  input wire [CMP_W-1:0]   out_compare_c,
  input wire [SEC_W-1:0]   out_sector
);

  // sector shown with a result is one to six
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sector != 3'd0 && out_sector != 3'd7))
    else $error("sector out of range");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // input is only held off when the result side is stalled
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output flows");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_compare_a)
      && $stable(out_compare_b) && $stable(out_compare_c) && $stable(out_sector))
    else $error("stalled result changed");

endmodule

bind space_vector_pwm_modulator svpwm_chk u_svpwm_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_compare_a (out_compare_a),
  .out_compare_b (out_compare_b),
  .out_compare_c (out_compare_c),
  .out_sector    (out_sector)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import svpwm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SEG_BEATS   = 120;
  localparam int NUM_SEGS    = 7;

  // one command beat and one comparator beat
  typedef struct packed {
    logic signed [UQ_W-1:0] uq_mv;
    logic [EANG_W-1:0]      angle;
  } svm_cmd_t;

  typedef struct packed {
    logic [CMP_W-1:0] cmp_a;
    logic [CMP_W-1:0] cmp_b;
    logic [CMP_W-1:0] cmp_c;
    logic [SEC_W-1:0] sector;
    logic             clipped;
  } svm_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [UQ_W-1:0] in_uq_mv = '0;
  logic [EANG_W-1:0] in_elec_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CMP_W-1:0] out_compare_a;
  logic [CMP_W-1:0] out_compare_b;
  logic [CMP_W-1:0] out_compare_c;
  logic [SEC_W-1:0] out_sector;
  logic cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_index = REG_INV_SUPPLY;
  logic [CFG_W-1:0] cfg_data = '0;

  space_vector_pwm_modulator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_uq_mv      (in_uq_mv),
    .in_elec_angle (in_elec_angle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_compare_a (out_compare_a),
    .out_compare_b (out_compare_b),
    .out_compare_c (out_compare_c),
    .out_sector    (out_sector),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  svm_cmd_t cmd_backlog[$];
  svm_out_t predicted_compares[$];
  svm_cmd_t cur_cmd;
  longint unsigned sin60_lut [0:SINE_N];
  logic [INV_W-1:0] mdl_inv_supply;
  logic [HALF_W-1:0] mdl_half_period;
  int send_idle_pct = 7;
  int recv_idle_pct = 55;
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int clipped_beats = 0;
  int reg_writes = 0;
  int cycle_cnt = 0;

  // sin(k/N * pi/3) in Q15 via a Q30 taylor series up to x^9
  function automatic longint unsigned sine_q15_entry(longint unsigned k);
    longint unsigned x, x2, term, acc;
    x    = (k * PI3_Q30) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 72;
    acc  = acc + term;
    return (acc + 64'd16384) >> 15;
  endfunction

  // active vector time in Q16: sqrt3 * sin * |uq| / supply
  function automatic longint unsigned active_q16(longint unsigned s, longint unsigned mag,
                                                 longint unsigned inv);
    longint unsigned v;
    v = (s * mag * longint'(SQRT3_Q15)) >> 15;
    return (v * inv) >> 31;
  endfunction

  // twice the duty, clamped to the rails, halved, scaled by the half period
  function automatic logic [CMP_W-1:0] duty_to_compare(longint x, longint t0,
                                                       longint unsigned half);
    longint d2;
    longint unsigned duty;
    d2 = 2 * x + t0;
    if (d2 < 0) d2 = 0;
    if (d2 > 2 * ONE_Q16) d2 = 2 * ONE_Q16;
    duty = longint'(d2) >> 1;
    return CMP_W'((duty * half) >> 16);
  endfunction

  function automatic svm_out_t svpwm_predict(svm_cmd_t c, logic [INV_W-1:0] inv,
                                             logic [HALF_W-1:0] half);
    longint unsigned amask, ang, mag, p, idx, t1, t2;
    longint a1, a2, t0, xa, xb, xc;
    logic [SEC_W-1:0] sec;
    svm_out_t r;
    amask = (64'd1 << ANGLE_BITS) - 1;
    ang = {48'd0, c.angle} & amask;
    // a negative command flips the vector by half a turn
    if (c.uq_mv[UQ_W-1]) begin
      mag = 64'h10000 - {48'd0, c.uq_mv};
      ang = (ang + (64'd1 << (ANGLE_BITS - 1))) & amask;
    end else begin
      mag = {48'd0, c.uq_mv};
    end
    p   = ang * 6;
    sec = SEC_W'(p >> ANGLE_BITS);
    idx = (p & amask) >> (ANGLE_BITS - SINE_TABLE_BITS);
    t1  = active_q16(sin60_lut[int'(SINE_N - idx)], mag, {41'd0, inv});
    t2  = active_q16(sin60_lut[int'(idx)], mag, {41'd0, inv});
    a1  = longint'(t1);
    a2  = longint'(t2);
    t0  = ONE_Q16 - a1 - a2;
    case (sec)
      SEC0: begin xa = a1 + a2; xb = a2;      xc = 0;       end
      SEC1: begin xa = a1;      xb = a1 + a2; xc = 0;       end
      SEC2: begin xa = 0;       xb = a1 + a2; xc = a2;      end
      SEC3: begin xa = 0;       xb = a1;      xc = a1 + a2; end
      SEC4: begin xa = a2;      xb = 0;       xc = a1 + a2; end
      default: begin xa = a1 + a2; xb = 0;    xc = a1;      end
    endcase
    r.cmp_a   = duty_to_compare(xa, t0, {48'd0, half});
    r.cmp_b   = duty_to_compare(xb, t0, {48'd0, half});
    r.cmp_c   = duty_to_compare(xc, t0, {48'd0, half});
    r.sector  = sec + 3'd1;
    r.clipped = (t0 < 0);
    return r;
  endfunction

  // mix of full range, rail and small commands; angles often near sector edges
  function automatic svm_cmd_t random_cmd();
    svm_cmd_t c;
    int kind;
    int k;
    kind = $urandom_range(9);
    if (kind == 0) begin
      case ($urandom_range(4))
        0: c.uq_mv = 16'sh8000;
        1: c.uq_mv = 16'sh7fff;
        2: c.uq_mv = 16'sh0000;
        3: c.uq_mv = 16'shffff;
        default: c.uq_mv = 16'sh0001;
      endcase
    end else if (kind <= 3) begin
      c.uq_mv = UQ_W'($urandom_range(8000) - 4000);
    end else begin
      c.uq_mv = UQ_W'($urandom);
    end
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(5);
      c.angle = EANG_W'((k * 65536 + 5) / 6 + $urandom_range(2) - 1);
    end else begin
      c.angle = EANG_W'($urandom);
    end
    return c;
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  // register mirror for the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      mdl_inv_supply  <= INV_SUPPLY_RST;
      mdl_half_period <= HALF_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_INV_SUPPLY:  mdl_inv_supply  <= cfg_data[INV_W-1:0];
        REG_HALF_PERIOD: mdl_half_period <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // command driver: predict on acceptance, then present the next beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_compares.push_back(svpwm_predict(cur_cmd, mdl_inv_supply, mdl_half_period));
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          in_valid      <= 1'b1;
          in_uq_mv      <= cur_cmd.uq_mv;
          in_elec_angle <= cur_cmd.angle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    svm_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_compares.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: a=%0d b=%0d c=%0d sector=%0d",
                     out_compare_a, out_compare_b, out_compare_c, out_sector);
        end else begin
          want = predicted_compares.pop_front();
          beats_checked++;
          if (want.clipped) clipped_beats++;
          if (out_compare_a !== want.cmp_a || out_compare_b !== want.cmp_b ||
              out_compare_c !== want.cmp_c || out_sector !== want.sector) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected a=%0d b=%0d c=%0d sector=%0d, got a=%0d b=%0d c=%0d sector=%0d",
                       want.cmp_a, want.cmp_b, want.cmp_c, want.sector,
                       out_compare_a, out_compare_b, out_compare_c, out_sector);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, predicted_compares.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_cmd(int uq, int ang);
    svm_cmd_t c;
    c.uq_mv = UQ_W'(uq);
    c.angle = EANG_W'(ang);
    cmd_backlog.push_back(c);
  endtask

  task automatic add_random_cmds(int n);
    for (int i = 0; i < n; i++) cmd_backlog.push_back(random_cmd());
  endtask

  // wait until the backlog is sent and every predicted beat has come back
  task automatic wait_until_drained();
    while (cmd_backlog.size() != 0 || in_valid || predicted_compares.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    @(negedge clk);
  endtask

  // stimulus sequencer
  initial begin
    logic [CFG_W-1:0] seg_inv [NUM_SEGS];
    logic [CFG_W-1:0] seg_half [NUM_SEGS];
    for (int k = 0; k <= SINE_N; k++) sin60_lut[k] = sine_q15_entry(longint'(k));
    seg_inv[0] = CFG_W'(INV_SUPPLY_RST); seg_half[0] = CFG_W'(HALF_PERIOD_RST);
    seg_inv[1] = 23'd65537;              seg_half[1] = 23'd65535;
    seg_inv[2] = 23'd4294967;            seg_half[2] = 23'd1;
    seg_inv[3] = 23'h7fffff;             seg_half[3] = 23'd65535;
    seg_inv[4] = 23'd0;                  seg_half[4] = 23'd2500;
    seg_inv[5] = CFG_W'($urandom_range(4294967, 65537));
    seg_half[5] = 23'd0;
    seg_inv[6] = CFG_W'($urandom_range(4294967, 65537));
    seg_half[6] = CFG_W'($urandom_range(65535, 1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed beats at the reset register values
    add_cmd(0, 0);
    add_cmd(0, 12345);
    add_cmd(32767, 0);
    add_cmd(-32768, 0);
    add_cmd(-32768, 65535);
    add_cmd(-1, 65535);
    add_cmd(32767, 65535);
    add_cmd(4000, 5461);
    add_cmd(-4000, 5461);
    add_cmd(3000, 10922);
    add_cmd(3000, 10923);
    add_cmd(3000, 21845);
    add_cmd(3000, 21846);
    add_cmd(3000, 32767);
    add_cmd(3000, 32768);
    add_cmd(3000, 43690);
    add_cmd(3000, 43691);
    add_cmd(3000, 54613);
    add_cmd(3000, 54614);
    add_cmd(20000, 16384);
    add_cmd(-20000, 49152);
    wait_until_drained();

    // random segments, each under its own register setting
    for (int s = 0; s < NUM_SEGS; s++) begin
      if (s == 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 7;
      end else if (s == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_INV_SUPPLY, seg_inv[s]);
      write_reg(REG_HALF_PERIOD, seg_half[s]);
      if (s == 2) begin
        add_random_cmds(SEG_BEATS / 2);
        wait_until_drained();
        add_random_cmds(SEG_BEATS / 2);
      end else begin
        add_random_cmds(SEG_BEATS);
      end
      wait_until_drained();
    end

    repeat (4 * PIPE_DEPTH) @(posedge clk);
    mismatches += predicted_compares.size();
    $display("sent %0d commands over %0d register writes, checked %0d results (%0d overmodulated)",
             beats_sent, reg_writes, beats_checked, clipped_beats);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/svpwm_pkg.sv
design/space_vector_pwm_modulator.sv
design/svpwm_chk.sv
tb/tb.sv
